### hw/rtl/bdac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdac_pkg
// shared types and constants of the buffered dac register block
// ----------------------------------------------------------------------------
package bdac_pkg;

   // item opcodes
   localparam logic [1:0] OP_READ    = 2'd0;
   localparam logic [1:0] OP_WRITE   = 2'd1;
   localparam logic [1:0] OP_TRIGGER = 2'd2;
   localparam logic [1:0] OP_TICK    = 2'd3;

   // register selects
   localparam logic [1:0] SEL_CONTROL = 2'd0;
   localparam logic [1:0] SEL_LOW     = 2'd1;
   localparam logic [1:0] SEL_HIGH    = 2'd2;
   localparam logic [1:0] SEL_NONE    = 2'd3;

   // pin actions reported on a tick
   localparam logic [1:0] PIN_UNCHANGED = 2'd0;
   localparam logic [1:0] PIN_DRIVE     = 2'd1;
   localparam logic [1:0] PIN_RELEASE   = 2'd2;

   // control register bit positions
   localparam int ENABLE_BIT        = 0;
   localparam int OUTPUT_ENABLE_BIT = 1;
   localparam int AUTO_TRIGGER_BIT  = 7;
   localparam int TRIG_SEL_LSB      = 4;
   localparam int TRIG_SEL_MSB      = 6;

   typedef struct packed {
      logic [7:0] rd_byte;
      logic [9:0] output_code;
      logic [1:0] pin_action;
   } bdac_result_type;

endpackage

### hw/rtl/bdac_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdac_core
// register state and single-pass item decode, result formed in the same cycle
// ----------------------------------------------------------------------------
module bdac_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [1:0]                opcode,
   input  logic [1:0]                reg_select,
   input  logic [7:0]                write_data,
   input  logic [3:0]                trigger_source,
   input  logic                      power_reduced,
   output bdac_pkg::bdac_result_type result
);

   logic [7:0] control_ff, control_in;
   logic [9:0] buffer_ff, buffer_in;
   logic [9:0] latched_ff, latched_in;
   logic [9:0] level_ff, level_in;
   logic       refresh;
   logic [7:0] rd;
   logic [1:0] pin;

   always_comb begin
      control_in = control_ff;
      buffer_in  = buffer_ff;
      latched_in = latched_ff;
      refresh    = 1'b0;
      rd         = 8'd0;
      pin        = bdac_pkg::PIN_UNCHANGED;
      unique case (opcode)
         bdac_pkg::OP_READ: begin
            case (reg_select)
               bdac_pkg::SEL_CONTROL: rd = control_ff;
               bdac_pkg::SEL_LOW:     rd = latched_ff[7:0];
               bdac_pkg::SEL_HIGH:    rd = {6'd0, latched_ff[9:8]};
               default:               rd = 8'd0;
            endcase
         end
         bdac_pkg::OP_WRITE: begin
            case (reg_select)
               bdac_pkg::SEL_CONTROL: begin
                  control_in = write_data;
                  refresh    = 1'b1;
               end
               bdac_pkg::SEL_LOW: begin
                  buffer_in = {buffer_ff[9:8], write_data};
                  if (!control_ff[bdac_pkg::AUTO_TRIGGER_BIT]) begin
                     latched_in = buffer_in;
                     refresh    = 1'b1;
                  end
               end
               bdac_pkg::SEL_HIGH: begin
                  buffer_in = {write_data[1:0], buffer_ff[7:0]};
                  if (!control_ff[bdac_pkg::AUTO_TRIGGER_BIT]) begin
                     latched_in = buffer_in;
                     refresh    = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         bdac_pkg::OP_TRIGGER: begin
            // sources above seven never match the three-bit select
            if (control_ff[bdac_pkg::AUTO_TRIGGER_BIT] &&
                trigger_source ==
                {1'b0, control_ff[bdac_pkg::TRIG_SEL_MSB:bdac_pkg::TRIG_SEL_LSB]}) begin
               latched_in = buffer_ff;
               refresh    = 1'b1;
            end
         end
         bdac_pkg::OP_TICK: begin
            if (!power_reduced) begin
               if (control_ff[bdac_pkg::ENABLE_BIT] &&
                   control_ff[bdac_pkg::OUTPUT_ENABLE_BIT])
                  pin = bdac_pkg::PIN_DRIVE;
               else
                  pin = bdac_pkg::PIN_RELEASE;
            end
         end
         default: ;
      endcase
      level_in = level_ff;
      if (refresh) begin
         if (power_reduced || !control_in[bdac_pkg::ENABLE_BIT])
            level_in = 10'd0;
         else
            level_in = latched_in;
      end
   end

   assign result.rd_byte     = rd;
   assign result.output_code = level_in;
   assign result.pin_action  = pin;

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff <= 8'd0;
         buffer_ff  <= 10'd0;
         latched_ff <= 10'd0;
         level_ff   <= 10'd0;
      end else if (accept) begin
         control_ff <= control_in;
         buffer_ff  <= buffer_in;
         latched_ff <= latched_in;
         level_ff   <= level_in;
      end
   end

endmodule

### hw/rtl/buffered_dac_register_block.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffered_dac_register_block
// 10-bit dac register block: control, data low/high, staging buffer, latch
// ----------------------------------------------------------------------------
// result: registered into the output register, or the skid entry on a stall
// throughput: one item per cycle, sustained while the result side keeps up
// a two-entry result buffer (output register plus skid) lets an item be
// taken while a finished result is still stalled
// reset: synchronous, clears control, buffer, latched data, level and valids
// ----------------------------------------------------------------------------
module buffered_dac_register_block (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [1:0] req_reg_select,
   input  logic [7:0] req_write_data,
   input  logic [3:0] req_trigger_source,
   input  logic       req_power_reduced,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic [9:0] rsp_output_code,
   output logic [1:0] rsp_pin_action
);

   bdac_pkg::bdac_result_type new_result;
   bdac_pkg::bdac_result_type out_ff, out_in;
   bdac_pkg::bdac_result_type skid_ff, skid_in;
   logic out_valid_ff, out_valid_in;
   logic skid_valid_ff, skid_valid_in;
   logic accept;
   logic drain;

   // stall only when the skid entry is taken, so it is a plain register
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign drain     = out_valid_ff && !rsp_stall;

   // state update and result decode for the accepted item
   bdac_core u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .opcode         (req_opcode),
      .reg_select     (req_reg_select),
      .write_data     (req_write_data),
      .trigger_source (req_trigger_source),
      .power_reduced  (req_power_reduced),
      .result         (new_result)
   );

   // result buffering: skid entry always older than a new item
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (drain || !out_valid_ff) begin
         if (skid_valid_ff) begin
            // skid full means no accept this cycle
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in       = new_result;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         // output held by a stall, park the new item
         skid_in       = new_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_read_data   = out_ff.rd_byte;
   assign rsp_output_code = out_ff.output_code;
   assign rsp_pin_action  = out_ff.pin_action;

endmodule
